/* design/bfba_pkg.sv */
// Shared constants, types and header helpers for the best-fit block allocator.
package bfba_pkg;

  // Store geometry
  localparam int HEAP_BYTES = 127;
  localparam int ADDR_W     = 7;
  localparam int SIZE_W     = 7;
  localparam int HDR_W      = SIZE_W + 1;
  localparam int WIDE_W     = SIZE_W + 1;

  localparam logic [WIDE_W-1:0] HEAP_END  = WIDE_W'(HEAP_BYTES);
  localparam logic [WIDE_W-1:0] NO_FIT    = WIDE_W'(2 ** SIZE_W);
  localparam logic [HDR_W-1:0]  RESET_HDR = {SIZE_W'(HEAP_BYTES), 1'b0};

  // Channel payloads
  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] payload_addr;
  } bfba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              failed;
  } bfba_out_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_SPLIT,
    ST_FREE_RD,
    ST_FREE_HDR,
    ST_FREE_NXT,
    ST_FREE_WR,
    ST_DONE
  } state_e;

  // Read address sources
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_FREE
  } rd_sel_e;

  // Write address and data sources
  typedef enum logic [1:0] {
    WR_BEST,
    WR_REST,
    WR_FREE
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    walk_step;
    logic    free_cap;
    logic    free_merge;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    out_load;
  } bfba_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic alloc_fail;
    logic split_rest;
    logic free_ok;
    logic merge_ok;
    logic out_ready;
  } bfba_status_t;

  function automatic logic [SIZE_W-1:0] hdr_size(input logic [HDR_W-1:0] h);
    return h[HDR_W-1:1];
  endfunction

  function automatic logic hdr_used(input logic [HDR_W-1:0] h);
    return h[0];
  endfunction

  function automatic logic [HDR_W-1:0] hdr_make(input logic [SIZE_W-1:0] sz,
                                                input logic used);
    return {sz, used};
  endfunction

endpackage

/* design/bfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bfba_ctrl.sv */
// Sequencer for the allocate walk and the free merge.
module bfba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  input  bfba_pkg::bfba_status_t status_i,
  output bfba_pkg::bfba_cmd_t    cmd_o,
  output logic                  busy_o
);
  import bfba_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_e'(in_kind_i) == KIND_FREE) ? ST_FREE_RD : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.walk_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.alloc_fail) begin
          state_d = ST_DONE;
        end else if (status_i.split_rest) begin
          state_d = ST_SPLIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SPLIT:    state_d = ST_DONE;
      ST_FREE_RD:  state_d = status_i.free_ok ? ST_FREE_HDR : ST_DONE;
      ST_FREE_HDR: state_d = status_i.merge_ok ? ST_FREE_NXT : ST_FREE_WR;
      ST_FREE_NXT: state_d = ST_FREE_WR;
      ST_FREE_WR:  state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_ready) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_HEAD;
    cmd_o.wr_sel = WR_BEST;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // start the walk at the first header right away
          if (kind_e'(in_kind_i) == KIND_ALLOC) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_HEAD;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (!status_i.walk_last) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
        end
      end
      ST_DECIDE: begin
        if (!status_i.alloc_fail) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_BEST;
        end
      end
      ST_SPLIT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_REST;
      end
      ST_FREE_RD: begin
        if (status_i.free_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_FREE;
        end
      end
      ST_FREE_HDR: begin
        cmd_o.free_cap = 1'b1;
        if (status_i.merge_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
        end
      end
      ST_FREE_NXT: cmd_o.free_merge = 1'b1;
      ST_FREE_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_FREE;
      end
      ST_DONE:     cmd_o.out_load = status_i.out_ready;
      default:     cmd_o = cmd_o;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* design/bfba_dpath.sv */
// Header store, walk registers and result register of the allocator.
module bfba_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfba_pkg::bfba_in_t     in_data_i,
  input  bfba_pkg::bfba_cmd_t    cmd_i,
  output bfba_pkg::bfba_status_t status_o,
  output logic                   out_valid_o,
  output bfba_pkg::bfba_out_t    out_data_o,
  input  logic                   out_stall_i
);
  import bfba_pkg::*;

  // Item registers
  logic              kind_q;
  logic [SIZE_W-1:0] req_q;
  logic [ADDR_W-1:0] pay_q;

  // Walk and merge registers
  logic [ADDR_W-1:0] cur_addr_q;
  logic [WIDE_W-1:0] best_size_q;
  logic [ADDR_W-1:0] best_addr_q;
  logic [SIZE_W-1:0] free_sz_q;

  // Store entry tracking: an unwritten entry reads as its reset value
  logic [HEAP_BYTES-1:0] vld_q;
  logic                  vld_rd_q;
  logic                  head_rd_q;

  // Result register
  logic      out_valid_q;
  bfba_out_t out_q;

  logic [HDR_W-1:0]  ram_rdata;
  logic [HDR_W-1:0]  hdr;
  logic [SIZE_W-1:0] sz;
  logic [WIDE_W-1:0] sz_w;
  logic [WIDE_W-1:0] need;
  logic [WIDE_W-1:0] next_addr;
  logic [WIDE_W-1:0] rest_addr;
  logic [WIDE_W-1:0] free_limit;
  logic [WIDE_W-1:0] merge_sum;
  logic [ADDR_W-1:0] free_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;
  logic              cand;
  logic              alloc_fail;
  bfba_out_t         res;

  // Header as seen by the walk
  assign hdr  = vld_rd_q ? ram_rdata : (head_rd_q ? RESET_HDR : '0);
  assign sz   = hdr_size(hdr);
  assign sz_w = {1'b0, sz};

  assign need       = {1'b0, req_q} + WIDE_W'(1);
  assign next_addr  = {1'b0, cur_addr_q} + sz_w;
  assign rest_addr  = {1'b0, best_addr_q} + need;
  assign free_addr  = pay_q - ADDR_W'(1);
  assign free_limit = HEAP_END - {1'b0, free_addr};
  assign merge_sum  = {1'b0, free_sz_q} + sz_w;

  assign cand = !hdr_used(hdr) && (sz_w >= need) && (sz_w < best_size_q);
  assign alloc_fail = (req_q == '0) || (best_size_q == NO_FIT);

  // Read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD: rd_addr = '0;
      RD_NEXT: rd_addr = next_addr[ADDR_W-1:0];
      RD_FREE: rd_addr = free_addr;
      default: rd_addr = '0;
    endcase
  end

  // Write address and header
  always_comb begin
    case (cmd_i.wr_sel)
      WR_BEST: begin
        wr_addr = best_addr_q;
        wr_data = hdr_make(need[SIZE_W-1:0], 1'b1);
      end
      WR_REST: begin
        wr_addr = rest_addr[ADDR_W-1:0];
        wr_data = hdr_make(SIZE_W'(best_size_q - need), 1'b0);
      end
      WR_FREE: begin
        wr_addr = free_addr;
        wr_data = hdr_make(free_sz_q, 1'b0);
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  bfba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Track written entries and tag each read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_rd_q  <= 1'b0;
      head_rd_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        vld_rd_q  <= vld_q[rd_addr];
        head_rd_q <= (rd_addr == '0);
      end
    end
  end

  // Capture the item, advance the walk, fold in the merge
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= in_data_i.kind;
      req_q       <= in_data_i.request_size;
      pay_q       <= in_data_i.payload_addr;
      best_size_q <= NO_FIT;
      best_addr_q <= '0;
    end
    if (cmd_i.rd_en) begin
      cur_addr_q <= rd_addr;
    end
    if (cmd_i.walk_step && cand) begin
      best_size_q <= sz_w;
      best_addr_q <= cur_addr_q;
    end
    if (cmd_i.free_cap) begin
      free_sz_q <= sz;
    end
    if (cmd_i.free_merge && !hdr_used(hdr)) begin
      free_sz_q <= (merge_sum > free_limit) ? free_limit[SIZE_W-1:0]
                                            : merge_sum[SIZE_W-1:0];
    end
  end

  // Result of the finished item
  always_comb begin
    res = '0;
    if (kind_e'(kind_q) == KIND_FREE) begin
      res.result_addr = pay_q;
    end else if (alloc_fail) begin
      res.failed = 1'b1;
    end else begin
      res.result_addr = best_addr_q + ADDR_W'(1);
    end
  end

  // Output register: hold until the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the sequencer
  assign status_o.walk_last  = (sz == '0) || (next_addr >= HEAP_END) || (req_q == '0);
  assign status_o.alloc_fail = alloc_fail;
  assign status_o.split_rest = (best_size_q != need) && (rest_addr < HEAP_END);
  assign status_o.free_ok    = (pay_q != '0) && ({1'b0, pay_q} <= HEAP_END);
  assign status_o.merge_ok   = (sz != '0) && (next_addr < HEAP_END);
  assign status_o.out_ready  = !out_valid_q || !out_stall_i;

endmodule

/* design/best_fit_block_allocator.sv */
// Top level of the best-fit block allocator over an implicit header list.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (bfba_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (bfba_out_t)
//
// An allocate walks the headers one per cycle through the registered
// read port of the header store. One item is in flight at a time; the
// result waits in an output register while the next item is taken.
// Reset restores one free block spanning the store at once, through
// per-entry written flags.
module best_fit_block_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bfba_pkg::bfba_in_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output bfba_pkg::bfba_out_t out_data_o,
  input  logic                out_stall_i
);
  import bfba_pkg::*;

  bfba_cmd_t    cmd;
  bfba_status_t status;
  logic         busy;

  bfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  bfba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // Take a new transfer only between items
  assign in_stall_o = busy;

endmodule

/* design/bfba_checker.sv */
// Port-level checks for the best-fit block allocator, bound to the top level.
module bfba_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input bfba_pkg::bfba_in_t  in_data_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input bfba_pkg::bfba_out_t out_data_o,
  input logic                out_stall_i
);
  import bfba_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is still in flight");

  // A failed allocate reports address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.result_addr == '0)
    else $error("failed result with nonzero address");

  // A fresh result appears only as an item finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in flight");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind best_fit_block_allocator bfba_props u_bfba_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_data_i   (in_data_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);

/* verif/bfba_checker.sv */
// Scoreboard for the best-fit block allocator: header-store prediction and result compare.
module bfba_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  bfba_pkg::bfba_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bfba_pkg::bfba_out_t out_data_i,
  output int                  mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bfba_pkg::*;

  // Best size seen so far starts above any block the store can hold
  localparam int WALK_NO_FIT = 2 ** SIZE_W;

  logic [HDR_W-1:0] header_bytes [HEAP_BYTES];
  bfba_out_t        expected_results_q [$];
  int               mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] bfba_checker: %s", $time, msg);
    mismatches++;
  endtask

  // Walk the header chain, take the smallest free block that fits, split the rest
  task automatic carve_block(input logic [SIZE_W-1:0] req, output bfba_out_t res);
    int need;
    int best_size;
    int best_at;
    int at;
    int sz;
    need      = int'(req) + 1;
    best_size = WALK_NO_FIT;
    best_at   = 0;
    at        = 0;
    res       = '0;
    while (req != 0 && at < HEAP_BYTES) begin
      sz = int'(header_bytes[at][HDR_W-1:1]);
      if (sz == 0) begin
        break;
      end
      if (!header_bytes[at][0] && sz >= need && sz < best_size) begin
        best_size = sz;
        best_at   = at;
      end
      at += sz;
    end
    if (req == 0 || best_size >= WALK_NO_FIT) begin
      res.failed = 1'b1;
    end else begin
      if (best_size == need) begin
        header_bytes[best_at] = {SIZE_W'(best_size), 1'b1};
      end else begin
        header_bytes[best_at] = {SIZE_W'(need), 1'b1};
        if (best_at + need < HEAP_BYTES) begin
          header_bytes[best_at + need] = {SIZE_W'(best_size - need), 1'b0};
        end
      end
      res.result_addr = ADDR_W'(best_at + 1);
    end
  endtask

  // Clear the used flag and absorb the following block when it is free
  task automatic release_block(input logic [ADDR_W-1:0] payload, output bfba_out_t res);
    int at;
    int sz;
    int nxt;
    res             = '0;
    res.result_addr = payload;
    if (payload != 0 && int'(payload) <= HEAP_BYTES) begin
      at  = int'(payload) - 1;
      sz  = int'(header_bytes[at][HDR_W-1:1]);
      nxt = at + sz;
      if (sz != 0 && nxt < HEAP_BYTES && !header_bytes[nxt][0]) begin
        sz += int'(header_bytes[nxt][HDR_W-1:1]);
        if (sz > HEAP_BYTES - at) begin
          sz = HEAP_BYTES - at;
        end
      end
      header_bytes[at] = {SIZE_W'(sz), 1'b0};
    end
  endtask

  // Compare each result transfer, then predict from each request transfer
  always @(posedge clk_i or negedge rst_ni) begin : track
    bfba_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < HEAP_BYTES; i++) begin
        header_bytes[i] = '0;
      end
      header_bytes[0] = RESET_HDR;
      expected_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: result_addr %0d failed %0b",
                                    out_data_i.result_addr, out_data_i.failed));
        end else begin
          want = expected_results_q.pop_front();
          if (out_data_i.result_addr !== want.result_addr) begin
            report_mismatch($sformatf("result_addr got %0d expected %0d",
                                      out_data_i.result_addr, want.result_addr));
          end
          if (out_data_i.failed !== want.failed) begin
            report_mismatch($sformatf("failed got %0b expected %0b",
                                      out_data_i.failed, want.failed));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_e'(in_data_i.kind) == KIND_ALLOC) begin
          carve_block(in_data_i.request_size, want);
        end else begin
          release_block(in_data_i.payload_addr, want);
        end
        expected_results_q.push_back(want);
      end
    end
  end

endmodule

/* verif/best_fit_block_allocator_tb.sv */
// Testbench top for the best-fit block allocator: clock, reset, traffic, stalls and verdict.
module best_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfba_pkg::*;

  typedef enum {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  bfba_in_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  bfba_out_t out_data;
  logic      out_stall = 1'b0;
  int        mismatch_count;

  kind_e       sent_kinds_q [$];
  int          live_addrs_q [$];
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  always #10 clk = ~clk;

  best_fit_block_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  bfba_checker checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count)
  );

  // Switch the receiver between stall patterns over windows of random length
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(4, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:     out_stall <= stall_left[1];
    endcase
  end

  // Track requests in flight and the payload addresses handed out
  always @(posedge clk) begin : follow
    kind_e k;
    if (rst_n) begin
      if (out_valid && !out_stall && sent_kinds_q.size() != 0) begin
        k = sent_kinds_q.pop_front();
        if (k == KIND_ALLOC && !out_data.failed) begin
          live_addrs_q.push_back(int'(out_data.result_addr));
        end
      end
      if (in_valid && !in_stall) begin
        sent_kinds_q.push_back(kind_e'(in_data.kind));
      end
    end
  end

  function automatic bfba_in_t make_req(input kind_e k, input int size, input int addr);
    bfba_in_t req;
    req.kind         = k;
    req.request_size = SIZE_W'(size);
    req.payload_addr = ADDR_W'(addr);
    return req;
  endfunction

  // Present one request inside a burst; open a new burst after a random gap
  task automatic send_item(input bfba_in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 160);
      end else begin
        gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int roll;
    int free_odds;
    int pick;
    int addr;
    int size;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: failures, exact fits, lone-header remainder, merges, stray frees
    send_item(make_req(KIND_ALLOC, 0, 127));
    send_item(make_req(KIND_ALLOC, 127, 0));
    send_item(make_req(KIND_ALLOC, 126, 0));
    send_item(make_req(KIND_ALLOC, 1, 0));
    send_item(make_req(KIND_FREE, 127, 1));
    send_item(make_req(KIND_ALLOC, 125, 0));
    send_item(make_req(KIND_FREE, 0, 1));
    send_item(make_req(KIND_FREE, 0, 0));
    send_item(make_req(KIND_FREE, 0, 127));
    send_item(make_req(KIND_ALLOC, 10, 0));
    send_item(make_req(KIND_ALLOC, 20, 0));
    send_item(make_req(KIND_ALLOC, 5, 0));
    send_item(make_req(KIND_FREE, 0, 12));
    send_item(make_req(KIND_ALLOC, 20, 0));
    send_item(make_req(KIND_FREE, 0, 12));
    send_item(make_req(KIND_ALLOC, 3, 0));
    send_item(make_req(KIND_FREE, 0, 1));
    send_item(make_req(KIND_FREE, 0, 12));
    send_item(make_req(KIND_FREE, 0, 1));
    send_item(make_req(KIND_FREE, 0, 50));

    // Random: mostly alloc and free of live blocks, some stray frees
    repeat (1800) begin
      roll      = $urandom_range(0, 99);
      free_odds = (live_addrs_q.size() > 24) ? 70 : 45;
      if (roll < 8) begin
        send_item(make_req(KIND_FREE, $urandom, $urandom_range(0, 127)));
      end else if (live_addrs_q.size() != 0 && roll < 8 + free_odds) begin
        pick = $urandom_range(0, live_addrs_q.size() - 1);
        addr = live_addrs_q[pick];
        live_addrs_q.delete(pick);
        send_item(make_req(KIND_FREE, $urandom, addr));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          size = 0;
        end else if (roll < 6) begin
          size = $urandom_range(100, 127);
        end else if (roll < 20) begin
          size = $urandom_range(17, 60);
        end else begin
          size = $urandom_range(1, 16);
        end
        send_item(make_req(KIND_ALLOC, size, $urandom));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let a free's latency pass
    while (sent_kinds_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("best_fit_block_allocator_tb passed");
    end else begin
      $display("best_fit_block_allocator_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("best_fit_block_allocator_tb failed");
    $finish;
  end

endmodule
